>>> design/pdmr_pkg.sv
// ----------------------------------------------------------------------------
// pdmr_pkg: shared constants and checksum helper
// Kind codes, register indexes, header constants and the folded
// one's-complement sum used by the DSCP mark and redirect unit.
// ----------------------------------------------------------------------------
package pdmr_pkg;

  localparam int unsigned MetricEntriesDefault   = 256;
  localparam int unsigned RedirectEntriesDefault = 256;

  localparam logic [1:0] KindPacket   = 2'd0;
  localparam logic [1:0] KindRedirect = 2'd1;
  localparam logic [1:0] KindMetrics  = 2'd2;

  localparam logic [1:0] RegEnable = 2'd0;
  localparam logic [1:0] RegDscp   = 2'd1;
  localparam logic [1:0] RegPort   = 2'd2;

  localparam logic [15:0] ServicePortReset = 16'd50051;
  localparam logic [15:0] EtherTypeIpv4    = 16'h0800;
  localparam logic [7:0]  ProtoTcp         = 8'd6;
  localparam logic [3:0]  MinHeaderWords   = 4'd5;
  localparam logic [16:0] EthTcpBytes      = 17'd34;

  // one's complement sum of four words, folded twice
  function automatic logic [15:0] fold_sum(input logic [15:0] a, input logic [15:0] b,
                                           input logic [15:0] c, input logic [15:0] d);
    logic [17:0] s;
    logic [16:0] t;
    logic [16:0] u;
    s = {2'b0, a} + {2'b0, b} + {2'b0, c} + {2'b0, d};
    t = {1'b0, s[15:0]} + {15'b0, s[17:16]};
    u = {1'b0, t[15:0]} + {16'b0, t[16]};
    return u[15:0];
  endfunction

endpackage

>>> design/packet_dscp_mark_and_redirect_unit.sv
// ----------------------------------------------------------------------------
// packet_dscp_mark_and_redirect_unit
// Marks DSCP, redirects destinations and keeps per-destination metrics.
// ----------------------------------------------------------------------------
// One item is in flight at a time. An item passes through the scan, update
// and output states, where the scan covers L slots, L being the larger of the
// two table fill counts (one key read per cycle from the key memories, scanned
// in step); then it waits for out_ready_i. Packets that fail the filters and
// unused kinds skip the scan. Tables fill from slot 0 upward and are never
// emptied, so a fill count stands in for the valid bits and no clearing pass
// follows reset. Configuration goes through the APB port at byte addresses
// 0 (enable), 4 (DSCP) and 8 (service port); pready is always high.
module packet_dscp_mark_and_redirect_unit #(
  parameter int unsigned METRIC_ENTRIES   = pdmr_pkg::MetricEntriesDefault,
  parameter int unsigned REDIRECT_ENTRIES = pdmr_pkg::RedirectEntriesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [15:0] ether_type_i,
  input  logic [7:0]  ip_protocol_i,
  input  logic [3:0]  header_words_i,
  input  logic [15:0] dest_port_i,
  input  logic [31:0] dest_addr_i,
  input  logic [7:0]  tos_in_i,
  input  logic [15:0] check_in_i,
  input  logic [15:0] frame_len_i,
  input  logic [15:0] captured_len_i,
  input  logic [63:0] now_ns_i,
  input  logic [31:0] target_addr_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        matched_o,
  output logic        redirected_o,
  output logic [7:0]  tos_out_o,
  output logic [31:0] dest_out_o,
  output logic [15:0] check_out_o,
  output logic        found_o,
  output logic [63:0] packet_count_o,
  output logic [63:0] byte_count_o,
  output logic [63:0] last_seen_o,
  output logic        table_full_o
);
  import pdmr_pkg::*;

  localparam int unsigned MIW = (METRIC_ENTRIES > 1) ? $clog2(METRIC_ENTRIES) : 1;
  localparam int unsigned RIW = (REDIRECT_ENTRIES > 1) ? $clog2(REDIRECT_ENTRIES) : 1;
  localparam int unsigned MCW = $clog2(METRIC_ENTRIES + 1);
  localparam int unsigned RCW = $clog2(REDIRECT_ENTRIES + 1);
  localparam int unsigned SCW = (MCW > RCW) ? MCW : RCW;

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StScan = 4'b0010,
    StRmw  = 4'b0100,
    StOut  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic        en_q;
  logic [5:0]  dscp_q;
  logic [15:0] port_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q   <= 1'b0;
      dscp_q <= '0;
      port_q <= ServicePortReset;
    end else if (cfg_wr && paddr[1:0] == 2'b00) begin
      case (paddr[3:2])
        RegEnable: en_q   <= pwdata[0];
        RegDscp:   dscp_q <= pwdata[5:0];
        RegPort:   port_q <= pwdata[15:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (paddr[3:2])
      RegEnable: prdata = {31'b0, en_q};
      RegDscp:   prdata = {26'b0, dscp_q};
      RegPort:   prdata = {16'b0, port_q};
      default:   prdata = '0;
    endcase
  end

  // memories: key, counters and targets
  logic [31:0] mkey_mem [METRIC_ENTRIES];
  logic [63:0] mpk_mem  [METRIC_ENTRIES];
  logic [63:0] mby_mem  [METRIC_ENTRIES];
  logic [63:0] mtm_mem  [METRIC_ENTRIES];
  logic [31:0] rkey_mem [REDIRECT_ENTRIES];
  logic [31:0] rtgt_mem [REDIRECT_ENTRIES];

  logic [MCW-1:0] mcnt_q;
  logic [RCW-1:0] rcnt_q;

  // latched item
  logic [1:0]  kind_q;
  logic        ok_q;
  logic [31:0] daddr_q;
  logic [7:0]  tos_q;
  logic [15:0] chk_q;
  logic [15:0] flen_q;
  logic [63:0] now_q;
  logic [31:0] tgt_q;

  // scan control
  logic [SCW-1:0] cnt_q, lim_q, pidx_q;
  logic           pend_q;
  logic [31:0]    mkey_rd, rkey_rd, rtgt_rd;
  logic [63:0]    mpk_rd, mby_rd, mtm_rd;
  logic           mhit_q, rhit_q;
  logic [MIW-1:0] midx_q;
  logic [RIW-1:0] ridx_q;
  logic [63:0]    hpk_q, hby_q, htm_q;
  logic [31:0]    htgt_q;

  logic ok_c;
  logic [SCW-1:0] lim_c;

  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    ok_c = en_q && ether_type_i == EtherTypeIpv4 && ip_protocol_i == ProtoTcp
        && header_words_i >= MinHeaderWords
        && {1'b0, captured_len_i} >= EthTcpBytes + {11'b0, header_words_i, 2'b00}
        && dest_port_i == port_q;
    if ((kind_i == KindPacket && ok_c) || kind_i == KindRedirect
        || kind_i == KindMetrics) begin
      lim_c = (SCW'(mcnt_q) > SCW'(rcnt_q)) ? SCW'(mcnt_q) : SCW'(rcnt_q);
    end else begin
      lim_c = '0;
    end
  end

  // memory reads at the scan address
  always_ff @(posedge clk_i) begin
    mkey_rd <= mkey_mem[cnt_q[MIW-1:0]];
    mpk_rd  <= mpk_mem[cnt_q[MIW-1:0]];
    mby_rd  <= mby_mem[cnt_q[MIW-1:0]];
    mtm_rd  <= mtm_mem[cnt_q[MIW-1:0]];
    rkey_rd <= rkey_mem[cnt_q[RIW-1:0]];
    rtgt_rd <= rtgt_mem[cnt_q[RIW-1:0]];
  end

  // rewrite and table update, evaluated in the RMW state
  logic        m_wr, m_ins, m_full;
  logic [MIW-1:0] m_idx;
  logic        r_wr, r_ins, r_full;
  logic [RIW-1:0] r_idx;
  logic [7:0]  nt;
  logic [7:0]  tos_c;
  logic [15:0] chk_c, s1, s2;
  logic [31:0] dest_c;
  logic        redir_c;

  always_comb begin
    m_wr = 1'b0; m_ins = 1'b0; m_full = 1'b0; m_idx = midx_q;
    r_wr = 1'b0; r_ins = 1'b0; r_full = 1'b0; r_idx = ridx_q;
    tos_c = tos_q; chk_c = chk_q; dest_c = daddr_q; redir_c = 1'b0;
    nt = {dscp_q, tos_q[1:0]};
    s1 = '0; s2 = '0;
    if (kind_q == KindPacket && ok_q) begin
      if (mhit_q) begin
        m_wr = 1'b1;
      end else if (MCW'(METRIC_ENTRIES) > mcnt_q) begin
        m_wr = 1'b1; m_ins = 1'b1; m_idx = mcnt_q[MIW-1:0];
      end else begin
        m_full = 1'b1;
      end
      if (dscp_q != 6'd0 && nt != tos_q) begin
        chk_c = ~fold_sum(~chk_q, ~{8'h00, tos_q}, {8'h00, nt}, 16'h0000);
        tos_c = nt;
      end
      if (rhit_q && htgt_q != 32'd0 && htgt_q != daddr_q) begin
        s1 = fold_sum(~chk_c, ~daddr_q[31:16], ~daddr_q[15:0], htgt_q[31:16]);
        s2 = fold_sum(s1, htgt_q[15:0], 16'h0000, 16'h0000);
        chk_c = ~s2;
        dest_c = htgt_q;
        redir_c = 1'b1;
      end
    end else if (kind_q == KindRedirect) begin
      if (rhit_q) begin
        r_wr = 1'b1;
      end else if (RCW'(REDIRECT_ENTRIES) > rcnt_q) begin
        r_wr = 1'b1; r_ins = 1'b1; r_idx = rcnt_q[RIW-1:0];
      end else begin
        r_full = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StRmw && m_wr) begin
      mkey_mem[m_idx] <= daddr_q;
      mpk_mem[m_idx]  <= m_ins ? 64'd1 : hpk_q + 64'd1;
      mby_mem[m_idx]  <= m_ins ? {48'b0, flen_q} : hby_q + {48'b0, flen_q};
      mtm_mem[m_idx]  <= now_q;
    end
    if (state_q == StRmw && r_wr) begin
      rkey_mem[r_idx] <= daddr_q;
      rtgt_mem[r_idx] <= tgt_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      kind_q  <= kind_i;
      ok_q    <= ok_c;
      daddr_q <= dest_addr_i;
      tos_q   <= tos_in_i;
      chk_q   <= check_in_i;
      flen_q  <= frame_len_i;
      now_q   <= now_ns_i;
      tgt_q   <= target_addr_i;
      lim_q   <= lim_c;
    end
    if (state_q == StScan && pend_q) begin
      if (pidx_q < SCW'(mcnt_q) && mkey_rd == daddr_q) begin
        midx_q <= pidx_q[MIW-1:0];
        hpk_q  <= mpk_rd;
        hby_q  <= mby_rd;
        htm_q  <= mtm_rd;
      end
      if (pidx_q < SCW'(rcnt_q) && rkey_rd == daddr_q) begin
        ridx_q <= pidx_q[RIW-1:0];
        htgt_q <= rtgt_rd;
      end
    end
    if (state_q == StScan && cnt_q < lim_q) begin
      pidx_q <= cnt_q;
    end
    if (state_q == StRmw) begin
      matched_o      <= (kind_q == KindPacket) && ok_q;
      redirected_o   <= redir_c;
      tos_out_o      <= (kind_q == KindPacket) ? tos_c : 8'd0;
      dest_out_o     <= (kind_q == KindPacket) ? dest_c : 32'd0;
      check_out_o    <= (kind_q == KindPacket) ? chk_c : 16'd0;
      found_o        <= (kind_q == KindMetrics) && mhit_q;
      packet_count_o <= (kind_q == KindMetrics && mhit_q) ? hpk_q : 64'd0;
      byte_count_o   <= (kind_q == KindMetrics && mhit_q) ? hby_q : 64'd0;
      last_seen_o    <= (kind_q == KindMetrics && mhit_q) ? htm_q : 64'd0;
      table_full_o   <= m_full | r_full;
    end
  end

  // control: scan counter, hit flags, fill counts, state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (in_valid_i) state_d = StScan;
      StScan:  if (cnt_q >= lim_q && !pend_q) state_d = StRmw;
      StRmw:   state_d = StOut;
      StOut:   if (out_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
      mhit_q  <= 1'b0;
      rhit_q  <= 1'b0;
      mcnt_q  <= '0;
      rcnt_q  <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        StIdle: begin
          cnt_q  <= '0;
          pend_q <= 1'b0;
          mhit_q <= 1'b0;
          rhit_q <= 1'b0;
        end
        StScan: begin
          // advance one slot per cycle, compare the slot read last cycle
          if (cnt_q < lim_q) begin
            cnt_q  <= cnt_q + SCW'(1);
            pend_q <= 1'b1;
          end else begin
            pend_q <= 1'b0;
          end
          if (pend_q && pidx_q < SCW'(mcnt_q) && mkey_rd == daddr_q) mhit_q <= 1'b1;
          if (pend_q && pidx_q < SCW'(rcnt_q) && rkey_rd == daddr_q) rhit_q <= 1'b1;
        end
        StRmw: begin
          if (m_ins) mcnt_q <= mcnt_q + MCW'(1);
          if (r_ins) rcnt_q <= rcnt_q + RCW'(1);
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o = (state_q == StOut);

`ifndef SYNTHESIS
  a_fill_metric: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mcnt_q <= MCW'(METRIC_ENTRIES)) else $error("metric fill count overflow");
  a_fill_redirect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rcnt_q <= RCW'(REDIRECT_ENTRIES)) else $error("redirect fill count overflow");
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("input taken while result pending");
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StRmw) |=> $stable(mcnt_q) && $stable(rcnt_q))
    else $error("fill count moved outside update");
`endif

endmodule
